// ----- sv/bpa_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Buddy page allocator package
// Shared request and response types, command codes and the sequencer states.
// ---------------------------------------------------------------------------
package bpa_pkg;

   localparam int FRAME_W = 20;
   localparam int LEVEL_W = 3;
   localparam logic [LEVEL_W-1:0] TAG_NONE = 3'd7;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type              cmd;
      logic [LEVEL_W-1:0]   level;
      logic [FRAME_W-1:0]   page_frame;
   } req_type;

   typedef struct packed {
      logic                 ok;
      logic [FRAME_W-1:0]   page_frame_out;
      logic [LEVEL_W-1:0]   level_out;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_A_SCAN,
      ST_UL_RD,
      ST_UL_WAIT,
      ST_UL_FIX,
      ST_A_SPLIT,
      ST_PUSH,
      ST_F_CHECK,
      ST_F_BRD,
      ST_F_BWAIT,
      ST_F_BEVAL,
      ST_DONE
   } state_type;

   // Per-page metadata word: level tag, allocated bit, listed bit.
   typedef struct packed {
      logic [LEVEL_W-1:0] tag;
      logic               taken;
      logic               listed;
   } meta_type;

   localparam meta_type META_RESET = '{tag: TAG_NONE, taken: 1'b0, listed: 1'b0};

endpackage

// ----- sv/bpa_mem.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Buddy page allocator page memory
// One synchronous RAM holding next link, previous link and metadata per page,
// one write port and one read port with a registered read.
// ---------------------------------------------------------------------------
module bpa_mem
   import bpa_pkg::*;
#(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int LW    = 13
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  logic [LW-1:0]   wr_next,
   input  logic [LW-1:0]   wr_prev,
   input  meta_type        wr_meta,
   input  logic [AW-1:0]   rd_addr,
   output logic [LW-1:0]   rd_next,
   output logic [LW-1:0]   rd_prev,
   output meta_type        rd_meta
);

   localparam int WW = 2 * LW + $bits(meta_type);

   logic [WW-1:0] ram_ff [DEPTH];
   logic [WW-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= {wr_next, wr_prev, wr_meta};
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= ram_ff[rd_addr];
   end

   assign {rd_next, rd_prev, rd_meta} = rd_data_ff;

endmodule

// ----- sv/buddy_page_allocator_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Buddy page allocator unit
// A bad level goes straight to the done state, which raises the strobe. Allocate
// runs an order scan and a head unlink, then per split an unlink, a push and a
// split step. Free runs a range check and an unlink, then per merge a buddy check,
// a buddy unlink and a tag update, and ends with a push.
// One request at a time; busy drops in the strobe cycle, and the receiver
// cannot stall. Synchronous reset, then a clearing pass over every page.
// ---------------------------------------------------------------------------
module buddy_page_allocator_unit
   import bpa_pkg::*;
#(
   parameter int MAX_ORDER  = 4,
   parameter int PAGE_COUNT = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_strobe,
   output rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [FRAME_W-1:0]   csr_wr_data
);

   localparam int AW = $clog2(PAGE_COUNT);
   localparam int LW = AW + 1;
   localparam int OW = $clog2(MAX_ORDER + 1);
   localparam logic [LW-1:0] NIL = LW'(PAGE_COUNT);

   // Registers.
   state_type            state_ff, state_in, ret_ff, ret_in;
   logic [FRAME_W-1:0]   base_ff;
   logic [LW-1:0]        head_ff [MAX_ORDER+1];
   logic [LW-1:0]        head_in [MAX_ORDER+1];
   req_type              req_ff, req_in;
   logic [AW:0]          clr_ff, clr_in;
   logic [LEVEL_W-1:0]   c_ff, c_in;     // current order
   logic [AW-1:0]        idx_ff, idx_in;
   logic [AW-1:0]        bud_ff, bud_in;
   logic [AW-1:0]        ul_ff, ul_in;   // page being unlinked
   logic [LW-1:0]        uln_ff, uln_in, ulp_ff, ulp_in;
   meta_type             ulm_ff, ulm_in;
   logic [1:0]           fix_ff, fix_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 strobe_ff, strobe_in;

   // Memory port.
   logic                 wr_en;
   logic [AW-1:0]        wr_addr, rd_addr;
   logic [LW-1:0]        wr_next, wr_prev, rd_next, rd_prev;
   meta_type             wr_meta, rd_meta;

   bpa_mem #(.DEPTH(PAGE_COUNT), .AW(AW), .LW(LW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_next (wr_next),
      .wr_prev (wr_prev),
      .wr_meta (wr_meta),
      .rd_addr (rd_addr),
      .rd_next (rd_next),
      .rd_prev (rd_prev),
      .rd_meta (rd_meta)
   );

   // Pending read-modify-write during unlink fixups lives in fix_ff:
   // bit 0 = prev neighbor next field, bit 1 = next neighbor prev field.
   logic [FRAME_W-1:0]   frame_off;

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         ret_ff    <= ST_IDLE;
         base_ff   <= '0;
         clr_ff    <= '0;
         strobe_ff <= 1'b0;
         fix_ff    <= '0;
         for (int i = 0; i <= MAX_ORDER; i++) head_ff[i] <= NIL;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         clr_ff    <= clr_in;
         strobe_ff <= strobe_in;
         fix_ff    <= fix_in;
         for (int i = 0; i <= MAX_ORDER; i++) head_ff[i] <= head_in[i];
         if (csr_wr_en) base_ff <= csr_wr_data;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      c_ff   <= c_in;
      idx_ff <= idx_in;
      bud_ff <= bud_in;
      ul_ff  <= ul_in;
      uln_ff <= uln_in;
      ulp_ff <= ulp_in;
      ulm_ff <= ulm_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;
   assign frame_off  = req_ff.page_frame - base_ff;

   // Sequencer: next state, memory commands and result.
   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      clr_in    = clr_ff;
      strobe_in = 1'b0;
      fix_in    = fix_ff;
      for (int i = 0; i <= MAX_ORDER; i++) head_in[i] = head_ff[i];
      req_in    = req_ff;
      c_in      = c_ff;
      idx_in    = idx_ff;
      bud_in    = bud_ff;
      ul_in     = ul_ff;
      uln_in    = uln_ff;
      ulp_in    = ulp_ff;
      ulm_in    = ulm_ff;
      rsp_in    = rsp_ff;
      wr_en     = 1'b0;
      wr_addr   = ul_ff;
      wr_next   = NIL;
      wr_prev   = NIL;
      wr_meta   = META_RESET;
      rd_addr   = ul_ff;

      case (state_ff)
         // Clearing pass: metadata to its reset value, one page a cycle.
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff[AW-1:0];
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == (AW+1)'(PAGE_COUNT - 1)) state_in = ST_IDLE;
         end

         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               c_in   = req_data.level;
               rsp_in = '0;
               if (req_data.level > LEVEL_W'(MAX_ORDER)) begin
                  state_in = ST_DONE;
               end else if (req_data.cmd == CMD_ALLOC) begin
                  state_in = ST_A_SCAN;
               end else begin
                  state_in = ST_F_CHECK;
               end
            end
         end

         // One order per cycle until a non-empty list or the top order.
         ST_A_SCAN: begin
            if (head_ff[c_ff[OW-1:0]] != NIL) begin
               idx_in   = head_ff[c_ff[OW-1:0]][AW-1:0];
               ul_in    = head_ff[c_ff[OW-1:0]][AW-1:0];
               ret_in   = ST_A_SPLIT;
               state_in = ST_UL_RD;
            end else if (c_ff == LEVEL_W'(MAX_ORDER)) begin
               state_in = ST_DONE;
            end else begin
               c_in = c_ff + 1'b1;
            end
         end

         // Unlink ul_ff: read its entry.
         ST_UL_RD: begin
            rd_addr  = ul_ff;
            state_in = ST_UL_WAIT;
         end

         ST_UL_WAIT: begin
            uln_in = rd_next;
            ulp_in = rd_prev;
            ulm_in = rd_meta;
            if (!rd_meta.listed) begin
               state_in = ret_ff;
            end else begin
               // Clear the page's links and listed bit now.
               wr_en   = 1'b1;
               wr_addr = ul_ff;
               wr_meta = '{tag: rd_meta.tag, taken: rd_meta.taken, listed: 1'b0};
               if (rd_prev == NIL && rd_meta.tag <= LEVEL_W'(MAX_ORDER) &&
                   head_ff[rd_meta.tag[OW-1:0]] == LW'(ul_ff)) begin
                  head_in[rd_meta.tag[OW-1:0]] = rd_next;
               end
               fix_in   = {rd_next != NIL, rd_prev != NIL};
               state_in = ST_UL_FIX;
               if (rd_next != NIL) rd_addr = rd_next[AW-1:0];
               else                rd_addr = rd_prev[AW-1:0];
            end
         end

         // Patch neighbors: each neighbor's read is issued in the cycle before its write.
         ST_UL_FIX: begin
            if (fix_ff[1]) begin
               // next neighbor entry is on the read port
               wr_en   = 1'b1;
               wr_addr = uln_ff[AW-1:0];
               wr_next = rd_next;
               wr_prev = ulp_ff;
               wr_meta = rd_meta;
               fix_in[1] = 1'b0;
               rd_addr = ulp_ff[AW-1:0];
            end else if (fix_ff[0]) begin
               wr_en   = 1'b1;
               wr_addr = ulp_ff[AW-1:0];
               wr_next = uln_ff;
               wr_prev = rd_prev;
               wr_meta = rd_meta;
               fix_in[0] = 1'b0;
            end
            // With both neighbors pending, stay in this state for the previous one.
            if (fix_ff != 2'b11) state_in = ret_ff;
         end

         // Mark allocated, then push upper halves down one order at a time.
         ST_A_SPLIT: begin
            if (ret_ff == ST_A_SPLIT) begin
               wr_en   = 1'b1;
               wr_addr = idx_ff;
               wr_meta = '{tag: req_ff.level, taken: 1'b1, listed: 1'b0};
               ret_in  = ST_IDLE;
            end
            if (c_ff == req_ff.level) begin
               rsp_in   = '{ok: 1'b1,
                            page_frame_out: base_ff + FRAME_W'(idx_ff),
                            level_out: req_ff.level};
               state_in = ST_DONE;
            end else begin
               c_in     = c_ff - 1'b1;
               bud_in   = AW'(LW'(idx_ff) + (LW'(1) << (c_ff - 1'b1)));
               if ((LW'(idx_ff) + (LW'(1) << (c_ff - 1'b1))) < NIL) begin
                  ul_in    = AW'(LW'(idx_ff) + (LW'(1) << (c_ff - 1'b1)));
                  ret_in   = ST_PUSH;
                  state_in = ST_UL_RD;
               end
            end
         end

         // Push bud_ff onto list c_ff; the old head's prev is read-modified.
         ST_PUSH: begin
            if (ret_ff == ST_PUSH) begin
               rd_addr = head_ff[c_ff[OW-1:0]][AW-1:0];
               ret_in  = ST_IDLE;
               wr_en   = 1'b1;
               wr_addr = bud_ff;
               wr_next = head_ff[c_ff[OW-1:0]];
               wr_prev = NIL;
               wr_meta = '{tag: c_ff, taken: ulm_ff.taken, listed: 1'b1};
               ulm_in  = '{tag: c_ff, taken: ulm_ff.taken, listed: 1'b1};
               uln_in  = head_ff[c_ff[OW-1:0]];
               head_in[c_ff[OW-1:0]] = LW'(bud_ff);
            end else begin
               if (uln_ff != NIL) begin
                  wr_en   = 1'b1;
                  wr_addr = uln_ff[AW-1:0];
                  wr_next = rd_next;
                  wr_prev = LW'(bud_ff);
                  wr_meta = rd_meta;
               end
               if (req_ff.cmd == CMD_ALLOC) begin
                  state_in = ST_A_SPLIT;
               end else begin
                  rsp_in   = '{ok: 1'b1,
                               page_frame_out: base_ff + FRAME_W'(bud_ff),
                               level_out: c_ff};
                  state_in = ST_DONE;
               end
            end
         end

         // Range check of the freed frame, then unlink it and clear taken.
         ST_F_CHECK: begin
            if (req_ff.page_frame < base_ff || frame_off >= FRAME_W'(PAGE_COUNT)) begin
               state_in = ST_DONE;
            end else if (ret_ff != ST_F_CHECK) begin
               idx_in   = frame_off[AW-1:0];
               ul_in    = frame_off[AW-1:0];
               ret_in   = ST_F_CHECK;
               state_in = ST_UL_RD;
            end else begin
               // The entry's metadata read during the unlink is in ulm_ff.
               wr_en   = 1'b1;
               wr_addr = idx_ff;
               wr_meta = '{tag: ulm_ff.tag, taken: 1'b0, listed: 1'b0};
               ulm_in  = '{tag: ulm_ff.tag, taken: 1'b0, listed: 1'b0};
               ret_in  = ST_IDLE;
               state_in = ST_F_BRD;
            end
         end

         // Look at the buddy of the current order.
         ST_F_BRD: begin
            bud_in = idx_ff ^ AW'(LW'(1) << c_ff);
            if (c_ff >= LEVEL_W'(MAX_ORDER) ||
                (LW'(idx_ff ^ AW'(LW'(1) << c_ff)) >= NIL) ||
                ((LW'(1) << c_ff) >= NIL)) begin
               bud_in   = idx_ff;
               ret_in   = ST_PUSH;
               state_in = ST_PUSH;
               ulm_in   = '{tag: ulm_ff.tag, taken: 1'b0, listed: 1'b0};
            end else begin
               rd_addr  = idx_ff ^ AW'(LW'(1) << c_ff);
               state_in = ST_F_BWAIT;
            end
         end

         ST_F_BWAIT: begin
            if (!rd_meta.listed || rd_meta.tag != c_ff || rd_meta.taken) begin
               bud_in   = idx_ff;
               ret_in   = ST_PUSH;
               state_in = ST_PUSH;
               ulm_in   = '{tag: ulm_ff.tag, taken: 1'b0, listed: 1'b0};
            end else begin
               ul_in    = bud_ff;
               ret_in   = ST_F_BEVAL;
               state_in = ST_UL_RD;
            end
         end

         // Buddy unlinked: invalidate both tags and climb an order.
         ST_F_BEVAL: begin
            if (ret_ff == ST_F_BEVAL) begin
               wr_en   = 1'b1;
               wr_addr = bud_ff;
               wr_meta = '{tag: TAG_NONE, taken: ulm_ff.taken, listed: 1'b0};
               ret_in  = ST_IDLE;
               rd_addr = idx_ff;
            end else begin
               wr_en   = 1'b1;
               wr_addr = idx_ff;
               wr_meta = '{tag: TAG_NONE, taken: rd_meta.taken, listed: 1'b0};
               ulm_in  = '{tag: TAG_NONE, taken: rd_meta.taken, listed: 1'b0};
               idx_in  = idx_ff & bud_ff;
               c_in    = c_ff + 1'b1;
               state_in = ST_F_BRD;
            end
         end

         ST_DONE: begin
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // The result strobe only follows the done state.
   a_strobe_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_DONE))
      else $error("response strobe without completion");

   // A request is never taken while busy, so state leaves idle only on start.
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff == ST_IDLE) && state_ff != ST_IDLE && $past(!reset)) |->
      $past(start))
      else $error("sequencer left idle without a request");

   // Failed responses carry zero payload.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.ok) |->
      (rsp_data.page_frame_out == '0 && rsp_data.level_out == '0))
      else $error("failed response with nonzero payload");

endmodule

// ----- tb/tb_buddy_page_allocator_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Buddy page allocator unit testbench
// Drives allocate and free requests with random idle bursts, predicts every
// response with a behavioral copy of the free lists and page tags, and checks
// each response field by field against the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module tb_buddy_page_allocator_unit;
   import bpa_pkg::*;

   localparam int MAX_ORDER  = 4;
   localparam int PAGE_COUNT = 4096;
   localparam int NIL        = PAGE_COUNT;
   localparam int SETTLE     = 60;
   localparam int CYCLE_LIMIT = 600000;

   // Behavioral allocator state and the queue of predicted responses.
   class alloc_scoreboard;
      rsp_type           pending[$];
      int                errors;
      int                checked;
      logic [FRAME_W-1:0] base;
      int                head[MAX_ORDER+1];
      int                nxt[PAGE_COUNT];
      int                prv[PAGE_COUNT];
      logic [2:0]        tag[PAGE_COUNT];
      bit                taken[PAGE_COUNT];
      bit                listed[PAGE_COUNT];

      function new();
         errors = 0;
         checked = 0;
         base = '0;
         foreach (head[i]) head[i] = NIL;
         for (int i = 0; i < PAGE_COUNT; i++) begin
            nxt[i] = 0;
            prv[i] = 0;
            tag[i] = TAG_NONE;
            taken[i] = 0;
            listed[i] = 0;
         end
      endfunction

      // Take a page off whatever list it sits on.
      function void unlink(int p);
         int n;
         int q;
         int lv;
         if (p >= NIL || !listed[p]) return;
         lv = tag[p];
         n = nxt[p];
         q = prv[p];
         if (q < NIL) nxt[q] = n;
         else if (lv <= MAX_ORDER && head[lv] == p) head[lv] = n;
         if (n < NIL) prv[n] = q;
         nxt[p] = NIL;
         prv[p] = NIL;
         listed[p] = 0;
      endfunction

      function void push(int p, int lv);
         int h;
         if (p >= NIL || lv > MAX_ORDER) return;
         unlink(p);
         tag[p] = LEVEL_W'(lv);
         h = head[lv];
         prv[p] = NIL;
         nxt[p] = h;
         if (h < NIL) prv[h] = p;
         head[lv] = p;
         listed[p] = 1;
      endfunction

      function rsp_type predict(req_type r);
         rsp_type res;
         int lvl;
         int c;
         int idx;
         int b;
         int lv;
         res = '0;
         lvl = r.level;
         idx = NIL;
         if (lvl > MAX_ORDER) return res;
         if (r.cmd == CMD_ALLOC) begin
            for (c = lvl; c <= MAX_ORDER; c++) begin
               idx = head[c];
               if (idx < NIL) break;
            end
            if (c > MAX_ORDER) return res;
            unlink(idx);
            tag[idx] = LEVEL_W'(lvl);
            taken[idx] = 1;
            while (c > lvl) begin
               c--;
               b = idx + (1 << c);
               if (b < NIL) push(b, c);
            end
            res.ok = 1'b1;
            res.page_frame_out = base + FRAME_W'(idx);
            res.level_out = LEVEL_W'(lvl);
            return res;
         end
         // Free: the frame must fall inside the region.
         if (r.page_frame < base) return res;
         idx = int'(r.page_frame - base);
         if (idx >= NIL) return res;
         unlink(idx);
         taken[idx] = 0;
         lv = lvl;
         while (lv < MAX_ORDER) begin
            b = idx ^ (1 << lv);
            if (b >= NIL) break;
            if (!listed[b] || tag[b] != lv || taken[b]) break;
            unlink(b);
            tag[b] = TAG_NONE;
            tag[idx] = TAG_NONE;
            idx = idx & b;
            lv++;
         end
         push(idx, lv);
         res.ok = 1'b1;
         res.page_frame_out = base + FRAME_W'(idx);
         res.level_out = LEVEL_W'(lv);
         return res;
      endfunction

      // Record an accepted request and return its predicted response.
      function rsp_type note_request(req_type r);
         rsp_type res;
         res = predict(r);
         pending.push_back(res);
         return res;
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report($sformatf("unexpected response %p", got));
         end else begin
            want = pending.pop_front();
            checked++;
            if (got.ok !== want.ok)
               report($sformatf("ok got %b want %b", got.ok, want.ok));
            if (got.page_frame_out !== want.page_frame_out)
               report($sformatf("page_frame_out got %h want %h",
                                got.page_frame_out, want.page_frame_out));
            if (got.level_out !== want.level_out)
               report($sformatf("level_out got %0d want %0d",
                                got.level_out, want.level_out));
         end
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   req_type            req_data;
   logic               rsp_strobe;
   rsp_type            rsp_data;
   logic               csr_wr_en;
   logic [FRAME_W-1:0] csr_wr_data;

   alloc_scoreboard sb;
   int  cycles;
   int  live_idx[$];
   int  live_lvl[$];
   bit  idling_on;
   int  frees_sent;
   int  allocs_sent;

   buddy_page_allocator_unit #(
      .MAX_ORDER(MAX_ORDER),
      .PAGE_COUNT(PAGE_COUNT)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Response monitor; results cannot be held off.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_response(rsp_data);
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Present one request and hold it until accepted; start stays high after.
   task send(input req_type r);
      rsp_type res;
      req_data <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      res = sb.note_request(r);
      if (r.cmd == CMD_ALLOC) allocs_sent++;
      else frees_sent++;
      // Track granted blocks so later frees are well formed.
      if (r.cmd == CMD_ALLOC && res.ok) begin
         live_idx.push_back(int'(FRAME_W'(res.page_frame_out - sb.base)));
         live_lvl.push_back(res.level_out);
      end
   endtask

   task idle_burst();
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clock);
   endtask

   task send_fields(input cmd_type c, input int lvl, input logic [FRAME_W-1:0] f);
      req_type r;
      r.cmd = c;
      r.level = LEVEL_W'(lvl);
      r.page_frame = f;
      send(r);
      if (idling_on && $urandom_range(0, 3) == 0) idle_burst();
   endtask

   // Stop sending, wait for all responses, then let the block go quiet.
   task drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task write_base(input logic [FRAME_W-1:0] v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.base = v;
   endtask

   function logic [FRAME_W-1:0] frame_of(int idx);
      return sb.base + FRAME_W'(idx);
   endfunction

   // Random mix: mostly well-formed alloc/free traffic, some noise.
   task random_phase(input int count);
      int k;
      int sel;
      int pick;
      req_type r;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 40) begin
            send_fields(CMD_ALLOC, $urandom_range(0, 9) == 0 ? $urandom_range(5, 7)
                                                             : $urandom_range(0, 4), '0);
         end else if (sel < 72 && live_idx.size() != 0) begin
            pick = $urandom_range(0, live_idx.size() - 1);
            k = live_idx[pick];
            sel = live_lvl[pick];
            live_idx.delete(pick);
            live_lvl.delete(pick);
            send_fields(CMD_FREE, sel, frame_of(k));
         end else if (sel < 85) begin
            send_fields(CMD_FREE, MAX_ORDER, frame_of($urandom_range(0, 31) * 16));
         end else if (sel < 92) begin
            send_fields(CMD_FREE, $urandom_range(0, 4),
                        frame_of($urandom_range(0, PAGE_COUNT - 1)));
         end else begin
            r.cmd = cmd_type'($urandom_range(0, 1));
            r.level = LEVEL_W'($urandom_range(0, 7));
            r.page_frame = FRAME_W'($urandom());
            send(r);
            if (idling_on && $urandom_range(0, 3) == 0) idle_burst();
         end
      end
   endtask

   initial begin
      sb = new();
      cycles = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      idling_on = 1'b1;
      frees_sent = 0;
      allocs_sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty pool, bad levels, out-of-region frames.
      send_fields(CMD_ALLOC, 0, '0);
      send_fields(CMD_ALLOC, 5, '0);
      send_fields(CMD_FREE, 7, 20'h00010);
      send_fields(CMD_FREE, 0, 20'hFFFFF);
      send_fields(CMD_FREE, 0, 20'd4096);
      // Seed the pool, then split and merge back.
      send_fields(CMD_FREE, MAX_ORDER, 20'd0);
      send_fields(CMD_FREE, MAX_ORDER, 20'd16);
      send_fields(CMD_ALLOC, 0, '0);
      send_fields(CMD_ALLOC, 2, '0);
      send_fields(CMD_ALLOC, MAX_ORDER, '0);
      send_fields(CMD_FREE, 0, 20'd0);
      send_fields(CMD_FREE, 2, 20'd4);
      // Freeing a block that is already on a list.
      send_fields(CMD_FREE, 1, 20'd2);
      // Unaligned free and a free near the top of the region.
      send_fields(CMD_FREE, 3, 20'd4090);
      send_fields(CMD_FREE, MAX_ORDER, 20'd4095);
      send_fields(CMD_ALLOC, 0, '0);
      send_fields(CMD_ALLOC, 3, '0);
      send_fields(CMD_FREE, 0, 20'd4095);
      send_fields(CMD_FREE, 6, 20'd4095);

      // Highest base: only frame FFFFF is inside, and frames wrap.
      write_base(20'hFFFFF);
      send_fields(CMD_FREE, 0, 20'h00000);
      send_fields(CMD_FREE, MAX_ORDER, 20'hFFFFF);
      send_fields(CMD_ALLOC, 1, '0);
      send_fields(CMD_ALLOC, 3, '0);

      write_base(20'h0);
      random_phase(150);
      write_base(20'h5A5A5);
      live_idx.delete();
      live_lvl.delete();
      random_phase(150);
      write_base(20'h0);
      live_idx.delete();
      live_lvl.delete();
      idling_on = 1'b0;
      random_phase(150);

      drain();
      if (sb.pending.size() != 0)
         sb.report($sformatf("%0d responses never arrived", sb.pending.size()));
      $display("Covered %0d allocate and %0d free requests over three region bases;",
               allocs_sent, frees_sent);
      $display("%0d responses checked, %0d mismatches.", sb.checked, sb.errors);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
